// ===== rtl/trc_pkg.sv =====
`default_nettype none

package trc_pkg;

    localparam int DIST_W   = 12;
    localparam int LEVEL_W  = 13;
    localparam int VOL_W    = 20;
    localparam int THR_W    = 8;
    localparam int TIME_W   = 32;
    localparam int PERIOD_W = 20;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int PROD_W   = VOL_W + DIST_W;
    localparam int DIV_CNT_W = $clog2(PROD_W);

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_TANK_HEIGHT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TANK_VOLUME  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RISE_THRESH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STALL_TMO    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_PERIOD = 3'd6;

    localparam logic [DIST_W-1:0]   RST_TANK_HEIGHT  = 12'd1000;
    localparam logic [DIST_W-1:0]   RST_MIN_LEVEL    = 12'd200;
    localparam logic [DIST_W-1:0]   RST_MAX_LEVEL    = 12'd800;
    localparam logic [VOL_W-1:0]    RST_TANK_VOLUME  = 20'd100000;
    localparam logic [THR_W-1:0]    RST_RISE_THRESH  = 8'd5;
    localparam logic [PERIOD_W-1:0] RST_STALL_TMO    = 20'd10000;
    localparam logic [PERIOD_W-1:0] RST_CHECK_PERIOD = 20'd5000;

    localparam logic [VOL_W-1:0] VOLUME_CAP = {VOL_W{1'b1}};

    // Operation codes of an input beat.
    localparam logic OP_MONITOR = 1'b0;
    localparam logic OP_LEVEL   = 1'b1;

    localparam logic [STATUS_W-1:0] FS_IDLE    = 2'd0;
    localparam logic [STATUS_W-1:0] FS_FILLING = 2'd1;
    localparam logic [STATUS_W-1:0] FS_FILLED  = 2'd2;
    localparam logic [STATUS_W-1:0] FS_TIMEOUT = 2'd3;

    typedef struct packed {
        logic load_in;
        logic calc_level;
        logic update;
        logic div_step;
        logic load_out;
    } trc_cmd_t;

    typedef struct packed {
        logic div_last;
    } trc_stat_t;

endpackage

`default_nettype wire

// ===== rtl/trc_ctrl.sv =====
`default_nettype none

module trc_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire trc_pkg::trc_stat_t stat,
    output trc_pkg::trc_cmd_t      cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LEVEL  = 3'd1;
    localparam logic [2:0] ST_UPDATE = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_OUT    = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_LEVEL;
                end
            end
            ST_LEVEL: begin
                cmd.calc_level = 1'b1;
                state_next     = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // The previous result must have left the output register first.
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid_next = cmd.load_out | (m_valid_reg & ~m_ready);
    assign m_valid      = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_LEVEL))
        else $error("accepted beat did not start level calculation");

    a_load_safe: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before it was taken");

    a_div_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && stat.div_last) |=> (state_reg == ST_OUT))
        else $error("divider finished but result stage not entered");

    a_busy_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("input accepted while a beat is in progress");

endmodule

`default_nettype wire

// ===== rtl/trc_datapath.sv =====
`default_nettype none

module trc_datapath (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire trc_pkg::trc_cmd_t                   cmd,
    output trc_pkg::trc_stat_t                       stat,
    input  wire logic                                cfg_we,
    input  wire logic [trc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [trc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                s_opcode,
    input  wire logic [trc_pkg::DIST_W-1:0]          s_distance_mm,
    input  wire logic [trc_pkg::TIME_W-1:0]          s_now_ms,
    output logic signed [trc_pkg::LEVEL_W-1:0]       m_level_mm,
    output logic                                     m_valve_open,
    output logic                                     m_warning,
    output logic [trc_pkg::STATUS_W-1:0]             m_fill_status,
    output logic [trc_pkg::VOL_W-1:0]                m_volume
);

    // Configuration registers.
    logic [trc_pkg::DIST_W-1:0]   height_reg, min_reg, max_reg;
    logic [trc_pkg::VOL_W-1:0]    tvol_reg;
    logic [trc_pkg::THR_W-1:0]    thr_reg;
    logic [trc_pkg::PERIOD_W-1:0] tmo_reg, period_reg;

    // Controller state kept across beats.
    logic                               filling_reg, filling_next;
    logic signed [trc_pkg::LEVEL_W-1:0] plevel_reg, plevel_next;
    logic [trc_pkg::TIME_W-1:0]         ptime_reg, ptime_next;
    logic [trc_pkg::TIME_W-1:0]         lcheck_reg, lcheck_next;
    logic                               warn_reg, warn_next;

    // Per-beat working registers.
    logic                               op_reg;
    logic [trc_pkg::DIST_W-1:0]         dist_reg;
    logic [trc_pkg::TIME_W-1:0]         now_reg;
    logic signed [trc_pkg::LEVEL_W-1:0] level_reg, level_next;
    logic [trc_pkg::STATUS_W-1:0]       status_reg, status_next;
    logic                               zero_vol_reg;

    // Divider.
    logic [trc_pkg::PROD_W-1:0]    quo_reg, quo_next;
    logic [trc_pkg::DIST_W-1:0]    rem_reg, rem_next;
    logic [trc_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [trc_pkg::DIST_W:0]      shifted;
    logic                          div_ge;
    logic [trc_pkg::PROD_W-1:0]    product;

    // Output register.
    logic signed [trc_pkg::LEVEL_W-1:0] out_level_reg;
    logic                               out_valve_reg, out_warn_reg;
    logic [trc_pkg::STATUS_W-1:0]       out_status_reg;
    logic [trc_pkg::VOL_W-1:0]          out_vol_reg, vol_final;

    logic signed [trc_pkg::LEVEL_W-1:0] min_s, max_s;
    logic signed [trc_pkg::LEVEL_W:0]   rise_lim;
    logic                               rise;
    logic [trc_pkg::TIME_W-1:0]         ptime_eff, since_check, since_prog;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_reg <= trc_pkg::RST_TANK_HEIGHT;
            min_reg    <= trc_pkg::RST_MIN_LEVEL;
            max_reg    <= trc_pkg::RST_MAX_LEVEL;
            tvol_reg   <= trc_pkg::RST_TANK_VOLUME;
            thr_reg    <= trc_pkg::RST_RISE_THRESH;
            tmo_reg    <= trc_pkg::RST_STALL_TMO;
            period_reg <= trc_pkg::RST_CHECK_PERIOD;
        end else if (cfg_we) begin
            case (cfg_index)
                trc_pkg::REG_TANK_HEIGHT:  height_reg <= cfg_data[trc_pkg::DIST_W-1:0];
                trc_pkg::REG_MIN_LEVEL:    min_reg    <= cfg_data[trc_pkg::DIST_W-1:0];
                trc_pkg::REG_MAX_LEVEL:    max_reg    <= cfg_data[trc_pkg::DIST_W-1:0];
                trc_pkg::REG_TANK_VOLUME:  tvol_reg   <= cfg_data[trc_pkg::VOL_W-1:0];
                trc_pkg::REG_RISE_THRESH:  thr_reg    <= cfg_data[trc_pkg::THR_W-1:0];
                trc_pkg::REG_STALL_TMO:    tmo_reg    <= cfg_data[trc_pkg::PERIOD_W-1:0];
                trc_pkg::REG_CHECK_PERIOD: period_reg <= cfg_data[trc_pkg::PERIOD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign level_next = $signed({1'b0, height_reg}) - $signed({1'b0, dist_reg});
    assign min_s      = $signed({1'b0, min_reg});
    assign max_s      = $signed({1'b0, max_reg});
    assign rise_lim   = $signed({plevel_reg[trc_pkg::LEVEL_W-1], plevel_reg})
                        + $signed({{(trc_pkg::LEVEL_W + 1 - trc_pkg::THR_W){1'b0}}, thr_reg});
    assign rise       = $signed({level_reg[trc_pkg::LEVEL_W-1], level_reg}) > rise_lim;
    assign ptime_eff  = rise ? now_reg : ptime_reg;
    assign since_check = now_reg - lcheck_reg;
    assign since_prog  = now_reg - ptime_eff;

    always_comb begin
        filling_next = filling_reg;
        plevel_next  = plevel_reg;
        ptime_next   = ptime_reg;
        lcheck_next  = lcheck_reg;
        warn_next    = warn_reg;
        status_next  = trc_pkg::FS_IDLE;
        if (op_reg == trc_pkg::OP_MONITOR) begin
            if (since_check >= {{(trc_pkg::TIME_W - trc_pkg::PERIOD_W){1'b0}}, period_reg}) begin
                lcheck_next = now_reg;
                warn_next   = (level_reg <= min_s);
            end
            status_next = filling_reg ? trc_pkg::FS_FILLING : trc_pkg::FS_IDLE;
        end else if (!filling_reg) begin
            if (level_reg <= min_s) begin
                if (level_reg <= max_s) begin
                    filling_next = 1'b1;
                    plevel_next  = level_reg;
                    ptime_next   = now_reg;
                    status_next  = trc_pkg::FS_FILLING;
                end else begin
                    // Minimum above maximum: opens and closes in the same beat.
                    status_next = trc_pkg::FS_FILLED;
                end
            end
        end else begin
            if (rise) begin
                plevel_next = level_reg;
            end
            ptime_next = ptime_eff;
            if (since_prog > {{(trc_pkg::TIME_W - trc_pkg::PERIOD_W){1'b0}}, tmo_reg}) begin
                filling_next = 1'b0;
                status_next  = trc_pkg::FS_TIMEOUT;
            end else if (level_reg > max_s) begin
                filling_next = 1'b0;
                status_next  = trc_pkg::FS_FILLED;
            end else begin
                status_next = trc_pkg::FS_FILLING;
            end
        end
    end

    assign product = {{trc_pkg::DIST_W{1'b0}}, tvol_reg}
                   * {{trc_pkg::VOL_W{1'b0}}, level_reg[trc_pkg::DIST_W-1:0]};

    // Restoring division, one quotient bit per cycle.
    assign shifted  = {rem_reg, quo_reg[trc_pkg::PROD_W-1]};
    assign div_ge   = shifted >= {1'b0, max_reg};
    assign rem_next = div_ge ? trc_pkg::DIST_W'(shifted - {1'b0, max_reg})
                             : shifted[trc_pkg::DIST_W-1:0];
    assign quo_next = {quo_reg[trc_pkg::PROD_W-2:0], div_ge};
    assign stat.div_last = (cnt_reg == trc_pkg::DIV_CNT_W'(trc_pkg::PROD_W - 1));

    assign vol_final = zero_vol_reg ? '0
                     : (quo_reg[trc_pkg::PROD_W-1:trc_pkg::VOL_W] != '0) ? trc_pkg::VOLUME_CAP
                     : quo_reg[trc_pkg::VOL_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filling_reg <= 1'b0;
            plevel_reg  <= '0;
            ptime_reg   <= '0;
            lcheck_reg  <= '0;
            warn_reg    <= 1'b0;
        end else if (cmd.update) begin
            filling_reg <= filling_next;
            plevel_reg  <= plevel_next;
            ptime_reg   <= ptime_next;
            lcheck_reg  <= lcheck_next;
            warn_reg    <= warn_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg   <= s_opcode;
            dist_reg <= s_distance_mm;
            now_reg  <= s_now_ms;
        end
        if (cmd.calc_level) begin
            level_reg <= level_next;
        end
        if (cmd.update) begin
            status_reg   <= status_next;
            zero_vol_reg <= (level_reg <= 0) || (max_reg == '0);
            quo_reg      <= product;
            rem_reg      <= '0;
            cnt_reg      <= '0;
        end else if (cmd.div_step) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.load_out) begin
            out_level_reg  <= level_reg;
            out_valve_reg  <= filling_reg;
            out_warn_reg   <= warn_reg;
            out_status_reg <= status_reg;
            out_vol_reg    <= vol_final;
        end
    end

    assign m_level_mm    = out_level_reg;
    assign m_valve_open  = out_valve_reg;
    assign m_warning     = out_warn_reg;
    assign m_fill_status = out_status_reg;
    assign m_volume      = out_vol_reg;

    a_valve_tracks_state: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> (m_valve_open == filling_reg))
        else $error("valve output disagrees with refill state");

    a_filling_status: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |=> (filling_reg == (status_reg == trc_pkg::FS_FILLING)))
        else $error("fill status disagrees with refill state");

endmodule

`default_nettype wire

// ===== rtl/tank_refill_controller.sv =====
// An accepted input beat passes the level, update and divider states into the result
// register, which drives m_valid. One beat is processed at a time, and the 32-step
// restoring divider forms the volume ratio one quotient bit per cycle.
// The result register frees the input side as soon as the result is loaded.
// Reset (aresetn low at a clock edge) restores the configuration registers to their
// default values, closes the valve and clears the warning and timing state.
`default_nettype none

module tank_refill_controller (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [trc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [trc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_opcode,
    input  wire logic [trc_pkg::DIST_W-1:0]        s_distance_mm,
    input  wire logic [trc_pkg::TIME_W-1:0]        s_now_ms,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [trc_pkg::LEVEL_W-1:0]     m_level_mm,
    output logic                                   m_valve_open,
    output logic                                   m_warning,
    output logic [trc_pkg::STATUS_W-1:0]           m_fill_status,
    output logic [trc_pkg::VOL_W-1:0]              m_volume
);

    trc_pkg::trc_cmd_t  cmd;
    trc_pkg::trc_stat_t stat;

    assign cfg_ready = 1'b1;

    trc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    trc_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_we        (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_opcode      (s_opcode),
        .s_distance_mm (s_distance_mm),
        .s_now_ms      (s_now_ms),
        .m_level_mm    (m_level_mm),
        .m_valve_open  (m_valve_open),
        .m_warning     (m_warning),
        .m_fill_status (m_fill_status),
        .m_volume      (m_volume)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb_tank_refill_controller.sv =====
`timescale 1ns / 1ps

module tb_tank_refill_controller;

    import trc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int DIST_MAX       = 4000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASES         = 9;
    localparam int PHASE_ITEMS    = 60;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] level;
        logic                      valve;
        logic                      warn;
        logic [STATUS_W-1:0]       status;
        logic [VOL_W-1:0]          volume;
    } tank_report_t;

    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        logic                  op;
        logic [DIST_W-1:0]     dist_mm;
        logic [TIME_W-1:0]     now;
        logic                  pinned;
        tank_report_t          want;
    } plan_row_t;

    logic                         aclk          = 1'b0;
    logic                         aresetn       = 1'b0;
    logic                         cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0]         cfg_index     = '0;
    logic [CFG_DATA_W-1:0]        cfg_data      = '0;
    logic                         s_valid       = 1'b0;
    logic                         s_opcode      = OP_MONITOR;
    logic [DIST_W-1:0]            s_distance_mm = '0;
    logic [TIME_W-1:0]            s_now_ms      = '0;
    logic                         m_ready       = 1'b0;
    logic                         cfg_ready;
    logic                         s_ready;
    logic                         m_valid;
    logic signed [LEVEL_W-1:0]    m_level_mm;
    logic                         m_valve_open;
    logic                         m_warning;
    logic [STATUS_W-1:0]          m_fill_status;
    logic [VOL_W-1:0]             m_volume;

    // Shadow copy of the registers and the refill state.
    logic [DIST_W-1:0]          height_mm     = RST_TANK_HEIGHT;
    logic [DIST_W-1:0]          min_mm        = RST_MIN_LEVEL;
    logic [DIST_W-1:0]          max_mm        = RST_MAX_LEVEL;
    logic [VOL_W-1:0]           capacity_ml   = RST_TANK_VOLUME;
    logic [THR_W-1:0]           rise_mm       = RST_RISE_THRESH;
    logic [PERIOD_W-1:0]        stall_ms      = RST_STALL_TMO;
    logic [PERIOD_W-1:0]        period_ms     = RST_CHECK_PERIOD;
    logic                       refilling     = 1'b0;
    logic signed [LEVEL_W-1:0]  mark_level    = '0;
    logic [TIME_W-1:0]          mark_time     = '0;
    logic [TIME_W-1:0]          last_check_ms = '0;
    logic                       low_warning   = 1'b0;

    tank_report_t report_q[$];
    plan_row_t    directed_plan[$];
    int           mismatches    = 0;
    int           quiet_cycles  = 0;
    int           sink_hold_len = 0;
    logic         src_gaps      = 1'b1;
    logic         sink_gaps     = 1'b1;

    tank_refill_controller dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_distance_mm (s_distance_mm),
        .s_now_ms      (s_now_ms),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_level_mm    (m_level_mm),
        .m_valve_open  (m_valve_open),
        .m_warning     (m_warning),
        .m_fill_status (m_fill_status),
        .m_volume      (m_volume)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic tank_report_t refill_predict(input logic op,
                                                    input logic [DIST_W-1:0] dist_mm,
                                                    input logic [TIME_W-1:0] now);
        tank_report_t     r;
        int               lvl;
        logic [TIME_W-1:0] span;
        longint unsigned  vol;
        lvl = int'(height_mm) - int'(dist_mm);
        r.status = FS_IDLE;
        if (op == OP_MONITOR) begin
            span = now - last_check_ms;
            if (span >= period_ms) begin
                last_check_ms = now;
                low_warning = (lvl <= int'(min_mm));
            end
            r.status = refilling ? FS_FILLING : FS_IDLE;
        end else if (!refilling) begin
            if (lvl <= int'(min_mm)) begin
                // With the minimum above the maximum the valve opens and shuts at once.
                if (lvl <= int'(max_mm)) begin
                    refilling = 1'b1;
                    mark_level = LEVEL_W'(lvl);
                    mark_time = now;
                    r.status = FS_FILLING;
                end else begin
                    r.status = FS_FILLED;
                end
            end
        end else begin
            if (lvl > int'(mark_level) + int'(rise_mm)) begin
                mark_level = LEVEL_W'(lvl);
                mark_time = now;
            end
            span = now - mark_time;
            if (span > stall_ms) begin
                refilling = 1'b0;
                r.status = FS_TIMEOUT;
            end else if (lvl > int'(max_mm)) begin
                refilling = 1'b0;
                r.status = FS_FILLED;
            end else begin
                r.status = FS_FILLING;
            end
        end
        if (lvl <= 0 || max_mm == 0) begin
            vol = 0;
        end else begin
            vol = 64'(capacity_ml) * 64'(lvl) / 64'(max_mm);
        end
        r.volume = (vol > VOLUME_CAP) ? VOLUME_CAP : VOL_W'(vol);
        r.level  = LEVEL_W'(lvl);
        r.valve  = refilling;
        r.warn   = low_warning;
        return r;
    endfunction

    function automatic logic [DIST_W-1:0] dist_for(input int lvl);
        int d;
        d = int'(height_mm) - lvl;
        if (d < 0) begin
            d = 0;
        end else if (d > DIST_MAX) begin
            d = DIST_MAX;
        end
        return DIST_W'(d);
    endfunction

    function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        plan_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.reg_data = data;
        return r;
    endfunction

    function automatic plan_row_t item_row(input logic op, input int dist_mm,
                                           input logic [TIME_W-1:0] now);
        plan_row_t r;
        r = '0;
        r.op = op;
        r.dist_mm = DIST_W'(dist_mm);
        r.now = now;
        return r;
    endfunction

    function automatic plan_row_t pinned_row(input logic op, input int dist_mm,
                                             input logic [TIME_W-1:0] now, input int level,
                                             input logic valve, input logic warn,
                                             input logic [STATUS_W-1:0] status,
                                             input int unsigned volume);
        plan_row_t r;
        r = item_row(op, dist_mm, now);
        r.pinned = 1'b1;
        r.want.level = LEVEL_W'(level);
        r.want.valve = valve;
        r.want.warn = warn;
        r.want.status = status;
        r.want.volume = VOL_W'(volume);
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken,
    // leaving cfg_valid high so that a following write needs no extra step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_TANK_HEIGHT:  height_mm = data[DIST_W-1:0];
            REG_MIN_LEVEL:    min_mm = data[DIST_W-1:0];
            REG_MAX_LEVEL:    max_mm = data[DIST_W-1:0];
            REG_TANK_VOLUME:  capacity_ml = data[VOL_W-1:0];
            REG_RISE_THRESH:  rise_mm = data[THR_W-1:0];
            REG_STALL_TMO:    stall_ms = data[PERIOD_W-1:0];
            REG_CHECK_PERIOD: period_ms = data[PERIOD_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic send_sample(input logic op, input logic [DIST_W-1:0] dist_mm,
                               input logic [TIME_W-1:0] now, input logic pinned,
                               input tank_report_t want);
        tank_report_t r;
        s_valid = 1'b1;
        s_opcode = op;
        s_distance_mm = dist_mm;
        s_now_ms = now;
        do @(posedge aclk); while (!s_ready);
        r = refill_predict(op, dist_mm, now);
        report_q.push_back(pinned ? want : r);
        @(negedge aclk);
        if (src_gaps && $urandom_range(0, 7) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
    endtask

    task automatic drain_results;
        s_valid = 1'b0;
        while (report_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    always begin : sink_pacing
        @(negedge aclk);
        if (sink_hold_len != 0) begin
            m_ready = 1'b0;
            repeat (sink_hold_len) @(negedge aclk);
            sink_hold_len = 0;
            m_ready = 1'b1;
        end else if (sink_gaps && $urandom_range(0, 9) == 0) begin
            m_ready = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
            m_ready = 1'b1;
        end else begin
            m_ready = 1'b1;
        end
    end

    always @(posedge aclk) begin : result_check
        tank_report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (report_q.size() == 0) begin
                $display("%0t: result beat with nothing expected, level_mm %0d status %0d",
                         $time, m_level_mm, m_fill_status);
                mismatches++;
            end else begin
                want = report_q.pop_front();
                if (m_level_mm !== want.level) begin
                    $display("%0t: level_mm expected %0d got %0d", $time, want.level,
                             m_level_mm);
                    mismatches++;
                end
                if (m_valve_open !== want.valve) begin
                    $display("%0t: valve_open expected %0d got %0d", $time, want.valve,
                             m_valve_open);
                    mismatches++;
                end
                if (m_warning !== want.warn) begin
                    $display("%0t: warning expected %0d got %0d", $time, want.warn,
                             m_warning);
                    mismatches++;
                end
                if (m_fill_status !== want.status) begin
                    $display("%0t: fill_status expected %0d got %0d", $time, want.status,
                             m_fill_status);
                    mismatches++;
                end
                if (m_volume !== want.volume) begin
                    $display("%0t: volume expected %0d got %0d", $time, want.volume,
                             m_volume);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tank_refill_controller regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        plan_row_t         row;
        logic [TIME_W-1:0] clock_ms;
        int unsigned       set_h, set_min, set_max, set_vol, set_rise, set_stall, set_period;
        int                lvl, lo, hi, depth, ramp, steps, count, phase;

        directed_plan = '{
            pinned_row(OP_MONITOR, 0, 32'd0, 1000, 1'b0, 1'b0, FS_IDLE, 125000),
            pinned_row(OP_MONITOR, 4000, 32'd5000, -3000, 1'b0, 1'b1, FS_IDLE, 0),
            item_row(OP_MONITOR, 0, 32'd9999),
            item_row(OP_MONITOR, 900, 32'd10000),
            item_row(OP_LEVEL, 0, 32'd10100),
            pinned_row(OP_LEVEL, 800, 32'd10200, 200, 1'b1, 1'b1, FS_FILLING, 25000),
            item_row(OP_LEVEL, 795, 32'd10300),
            item_row(OP_LEVEL, 794, 32'd10400),
            item_row(OP_MONITOR, 500, 32'd15400),
            pinned_row(OP_LEVEL, 199, 32'd15500, 801, 1'b0, 1'b0, FS_FILLED, 100125),
            item_row(OP_LEVEL, 1000, 32'd16000),
            item_row(OP_LEVEL, 1000, 32'd26000),
            pinned_row(OP_LEVEL, 1000, 32'd26001, 0, 1'b0, 1'b0, FS_TIMEOUT, 0),
            // Stall timing across the wrap of the millisecond counter.
            item_row(OP_LEVEL, 4000, 32'hFFFF_FF00),
            item_row(OP_LEVEL, 4000, 32'h0000_2000),
            item_row(OP_LEVEL, 4000, 32'h0000_2611),
            item_row(OP_MONITOR, 4000, 32'hFFFF_FFFF),
            item_row(OP_MONITOR, 0, 32'h0000_1000),
            reg_row(REG_MAX_LEVEL, 20'd0),
            reg_row(REG_MIN_LEVEL, 20'd300),
            pinned_row(OP_LEVEL, 800, 32'h0000_2000, 200, 1'b0, 1'b1, FS_FILLED, 0),
            reg_row(REG_CHECK_PERIOD, 20'd0),
            pinned_row(OP_MONITOR, 0, 32'h0000_1001, 1000, 1'b0, 1'b0, FS_IDLE, 0),
            reg_row(REG_MAX_LEVEL, 20'd1),
            reg_row(REG_TANK_VOLUME, 20'hFFFFF),
            reg_row(REG_UNUSED, 20'hFFFFF),
            pinned_row(OP_LEVEL, 0, 32'h0000_3000, 1000, 1'b0, 1'b0, FS_IDLE, VOLUME_CAP),
            reg_row(REG_TANK_HEIGHT, 20'd4000),
            reg_row(REG_RISE_THRESH, 20'd255),
            reg_row(REG_STALL_TMO, 20'd1000000),
            item_row(OP_LEVEL, 0, 32'h0000_4000),
            reg_row(REG_TANK_HEIGHT, 20'd0),
            reg_row(REG_MIN_LEVEL, 20'd4000),
            reg_row(REG_MAX_LEVEL, 20'd4000),
            item_row(OP_LEVEL, 4000, 32'h0000_5000),
            item_row(OP_LEVEL, 0, 32'h0000_6000),
            item_row(OP_MONITOR, 2048, 32'h8000_0000)
        };

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_plan[i]) begin
            row = directed_plan[i];
            if (row.is_cfg) begin
                // The first write of a group waits for the block to go idle.
                if (!cfg_valid) begin
                    drain_results();
                end
                write_reg(row.reg_idx, row.reg_data);
            end else begin
                cfg_valid = 1'b0;
                send_sample(row.op, row.dist_mm, row.now, row.pinned, row.want);
            end
        end
        cfg_valid = 1'b0;

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    set_h = 4000; set_min = 4000; set_max = 4000; set_vol = 20'hFFFFF;
                    set_rise = 255; set_stall = 1000000; set_period = 1000000;
                end
                1: begin
                    set_h = 0; set_min = 0; set_max = 0; set_vol = 0;
                    set_rise = 0; set_stall = 0; set_period = 0;
                end
                2: begin
                    // Minimum above maximum.
                    set_h = $urandom_range(1000, 4000);
                    set_max = $urandom_range(0, set_h / 2);
                    set_min = $urandom_range(set_max + 1, set_h);
                    set_vol = $urandom_range(0, 20'hFFFFF);
                    set_rise = $urandom_range(0, 40);
                    set_stall = $urandom_range(200, 5000);
                    set_period = $urandom_range(0, 3000);
                end
                default: begin
                    set_h = $urandom_range(500, 4000);
                    set_max = $urandom_range(50, set_h);
                    set_min = $urandom_range(0, set_max);
                    set_vol = $urandom_range(0, 20'hFFFFF);
                    set_rise = $urandom_range(0, 40);
                    set_stall = $urandom_range(200, 5000);
                    set_period = $urandom_range(0, 3000);
                end
            endcase
            drain_results();
            write_reg(REG_TANK_HEIGHT, CFG_DATA_W'(set_h));
            write_reg(REG_MIN_LEVEL, CFG_DATA_W'(set_min));
            write_reg(REG_MAX_LEVEL, CFG_DATA_W'(set_max));
            write_reg(REG_TANK_VOLUME, CFG_DATA_W'(set_vol));
            write_reg(REG_RISE_THRESH, CFG_DATA_W'(set_rise));
            write_reg(REG_STALL_TMO, CFG_DATA_W'(set_stall));
            write_reg(REG_CHECK_PERIOD, CFG_DATA_W'(set_period));
            cfg_valid = 1'b0;

            clock_ms = $urandom;
            count = 0;

            if (phase == 3) begin
                // Hold the result side off while beats keep coming, until the input stalls.
                src_gaps = 1'b0;
                sink_hold_len = LONG_HOLD;
                repeat (12) begin
                    clock_ms = clock_ms + $urandom_range(0, 300);
                    send_sample(1'($urandom_range(0, 1)),
                                DIST_W'($urandom_range(0, DIST_MAX)),
                                clock_ms, 1'b0, '0);
                    count++;
                end
            end

            while (count < PHASE_ITEMS) begin
                if (phase == PHASES - 1) begin
                    src_gaps = 1'b0;
                    sink_gaps = 1'b0;
                end else begin
                    src_gaps = ($urandom_range(0, 3) != 0);
                    sink_gaps = ($urandom_range(0, 3) != 0);
                end

                if ($urandom_range(0, 4) == 0) begin
                    if ($urandom_range(0, 7) == 0) begin
                        clock_ms = $urandom;
                    end else begin
                        clock_ms = clock_ms + $urandom_range(0, 2000);
                    end
                    send_sample(1'($urandom_range(0, 1)),
                                DIST_W'($urandom_range(0, DIST_MAX)),
                                clock_ms, 1'b0, '0);
                    count++;
                end else begin
                    // A refill run: start at or below the minimum, then climb with stalls.
                    lo = int'(height_mm) - DIST_MAX;
                    hi = (min_mm < height_mm) ? int'(min_mm) : int'(height_mm);
                    if (hi < lo) begin
                        hi = lo;
                    end
                    depth = hi - lo;
                    if (depth > 400 && $urandom_range(0, 3) != 0) begin
                        depth = 400;
                    end
                    lvl = hi - int'($urandom_range(0, depth));
                    clock_ms = clock_ms + $urandom_range(0, 300);
                    send_sample(OP_LEVEL, dist_for(lvl), clock_ms, 1'b0, '0);
                    count++;
                    ramp = (int'(max_mm) - lvl) / 8;
                    if (ramp < 1) begin
                        ramp = 1;
                    end
                    steps = 0;
                    while (refilling && steps < 40 && count < PHASE_ITEMS) begin
                        steps++;
                        count++;
                        clock_ms = clock_ms + $urandom_range(0, 300);
                        if ($urandom_range(0, 3) == 0) begin
                            if ($urandom_range(0, 1) == 0) begin
                                clock_ms = clock_ms + period_ms;
                            end
                            send_sample(OP_MONITOR,
                                        dist_for(lvl + int'($urandom_range(0, 20)) - 10),
                                        clock_ms, 1'b0, '0);
                        end else begin
                            if ($urandom_range(0, 11) == 0) begin
                                clock_ms = clock_ms + stall_ms + $urandom_range(0, 2);
                            end else begin
                                lvl = lvl + int'($urandom_range(0, 2 * ramp)) - ramp / 4;
                            end
                            lvl = int'(height_mm) - int'(dist_for(lvl));
                            send_sample(OP_LEVEL, dist_for(lvl), clock_ms, 1'b0, '0);
                        end
                    end
                end
            end
        end

        drain_results();
        if (mismatches == 0) begin
            $display("tank_refill_controller regression: pass");
        end else begin
            $display("tank_refill_controller regression: fail");
        end
        $finish;
    end

endmodule
